/* sv/dotted_quad_ipv4_parse_classify_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dotted-quad IPv4 parser
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DOTTED_QUAD_IPV4_PARSE_CLASSIFY_ASSERT_SVH
`define DOTTED_QUAD_IPV4_PARSE_CLASSIFY_ASSERT_SVH

// same-cycle implication
`define DQIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dqip check failed");

// next-cycle implication
`define DQIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dqip check failed");

`endif

/* sv/dqip_pkg.sv */
// ----------------------------------------------------------------------------
// dqip_pkg
// Beat types and constants of the dotted-quad IPv4 parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dqip_pkg;

  localparam int unsigned OctetMax   = 255;
  localparam int unsigned ClassATop  = 127;
  localparam int unsigned ClassBTop  = 191;
  localparam int unsigned ClassCTop  = 223;
  localparam int unsigned ClassDTop  = 239;
  localparam int unsigned Radix      = 10;
  localparam int unsigned DotsNeeded = 3;
  localparam int unsigned DotSat     = 7;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharDot  = 8'h2E;

  typedef enum logic [2:0] {
    ClassA = 3'd0,
    ClassB = 3'd1,
    ClassC = 3'd2,
    ClassD = 3'd3,
    ClassE = 3'd4
  } addr_class_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic        addr_valid;
    logic [31:0] parsed_addr;
    logic [2:0]  addr_class;
    logic [31:0] network_addr;
    logic [31:0] broadcast_addr;
  } out_beat_t;

endpackage

`default_nettype wire

/* sv/dotted_quad_ipv4_parse_classify.sv */
// ----------------------------------------------------------------------------
// dotted_quad_ipv4_parse_classify
// Parses dotted-decimal IPv4 text one character per beat and, on the last
// character, returns validity, address, classful class, network, broadcast.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  input   | in        | in_valid_i / in_stall_o   | in_data_i  (in_beat_t)
//  output  | out       | out_valid_o / out_stall_i | out_data_o (out_beat_t)
//
//  One character per cycle unless stalled; a beat goes through the input
//  register and, if it is the last character, then the result register.
//  The rate is set by the combinational octet multiply-add on the input register.
//  Reset clears the parse state and both valid flags; no clearing pass.
//  A stalled result holds; the input stalls only when a last character waits
//  in the input register behind a held result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dotted_quad_ipv4_parse_classify_assert.svh"

module dotted_quad_ipv4_parse_classify
  import dqip_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  // input register
  logic     s1_vld_q;
  in_beat_t s1_q;

  // parse state
  logic [7:0]  octet_q,  octet_d;
  logic        ovf_q,    ovf_d;
  logic        digit_q,  digit_d;
  logic [2:0]  dots_q,   dots_d;
  logic [23:0] done_q,   done_d;
  logic        bad_q,    bad_d;

  // result register
  logic      out_vld_q;
  out_beat_t out_q, out_d;

  logic out_free, s1_move, s1_fin, in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_move    = s1_vld_q && (!s1_q.last_char || out_free);
  assign s1_fin     = s1_move && s1_q.last_char;
  assign in_stall_o = s1_vld_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  // character step
  logic        is_digit, is_dot;
  logic [11:0] acc_next;
  logic [3:0]  digit_val;
  logic [7:0]  char_off;

  always_comb begin
    is_digit  = (s1_q.char_code >= CharZero) && (s1_q.char_code <= CharNine);
    is_dot    = (s1_q.char_code == CharDot);
    char_off  = s1_q.char_code - CharZero;
    digit_val = char_off[3:0];
    acc_next  = 12'(octet_q) * 12'(Radix) + 12'(digit_val);

    octet_d = octet_q;
    ovf_d   = ovf_q;
    digit_d = digit_q;
    dots_d  = dots_q;
    done_d  = done_q;
    bad_d   = bad_q;

    if (is_digit) begin
      if (acc_next > 12'(OctetMax)) begin
        ovf_d   = 1'b1;
        octet_d = 8'(OctetMax);
      end else begin
        octet_d = acc_next[7:0];
      end
      digit_d = 1'b1;
    end else if (is_dot) begin
      if (!digit_q) begin
        bad_d = 1'b1;
      end
      // dots past the third leave the closed octets alone
      if (dots_q < 3'(DotsNeeded)) begin
        done_d = {done_q[15:0], octet_q};
      end
      if (dots_q < 3'(DotSat)) begin
        dots_d = dots_q + 3'd1;
      end
      octet_d = '0;
      digit_d = 1'b0;
    end else begin
      bad_d = 1'b1;
    end
  end

  // classify the closed string
  logic        str_ok;
  logic [31:0] addr, host;
  logic [7:0]  top;
  addr_class_e cls;

  always_comb begin
    str_ok = !bad_d && !ovf_d && digit_d && (dots_d == 3'(DotsNeeded));
    addr   = {done_d, octet_d};
    top    = addr[31:24];

    priority if (top <= 8'(ClassATop)) begin
      cls  = ClassA;
      host = 32'h00FF_FFFF;
    end else if (top <= 8'(ClassBTop)) begin
      cls  = ClassB;
      host = 32'h0000_FFFF;
    end else if (top <= 8'(ClassCTop)) begin
      cls  = ClassC;
      host = 32'h0000_00FF;
    end else if (top <= 8'(ClassDTop)) begin
      cls  = ClassD;
      host = '0;
    end else begin
      cls  = ClassE;
      host = '0;
    end

    out_d = '0;
    if (str_ok) begin
      out_d.addr_valid  = 1'b1;
      out_d.parsed_addr = addr;
      out_d.addr_class  = cls;
      if (cls == ClassA || cls == ClassB || cls == ClassC) begin
        out_d.network_addr   = addr & ~host;
        out_d.broadcast_addr = addr | host;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      octet_q   <= '0;
      ovf_q     <= 1'b0;
      digit_q   <= 1'b0;
      dots_q    <= '0;
      done_q    <= '0;
      bad_q     <= 1'b0;
    end else begin
      if (in_take) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end

      if (s1_fin) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      if (s1_fin) begin
        // string closed: start the next one from scratch
        octet_q <= '0;
        ovf_q   <= 1'b0;
        digit_q <= 1'b0;
        dots_q  <= '0;
        done_q  <= '0;
        bad_q   <= 1'b0;
      end else if (s1_move) begin
        octet_q <= octet_d;
        ovf_q   <= ovf_d;
        digit_q <= digit_d;
        dots_q  <= dots_d;
        done_q  <= done_d;
        bad_q   <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
    if (s1_fin) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `DQIP_ASSERT_NEXT(a_fin_gives_result, s1_fin, out_valid_o)
  `DQIP_ASSERT_NEXT(a_fin_clears_state, s1_fin, dots_q == 3'd0 && !digit_q && !bad_q && !ovf_q)
  `DQIP_ASSERT_NOW(a_bad_is_zero, out_valid_o && !out_data_o.addr_valid,
                   out_data_o.parsed_addr == 32'd0 && out_data_o.network_addr == 32'd0)
  `DQIP_ASSERT_NOW(a_no_host_de, out_valid_o && out_data_o.parsed_addr[31:29] == 3'b111,
                   out_data_o.network_addr == 32'd0 && out_data_o.broadcast_addr == 32'd0)

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives dotted-decimal text into the IPv4 parser one character per beat.
// An in-bench parser predicts each result, which is checked field by field.
// Stimulus covers directed class edges and malformed text, then random quads and noise.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import dqip_pkg::*;
();

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  dotted_quad_ipv4_parse_classify dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // parse state mirrored by the predictor
  logic [7:0]  octet_val;
  bit          octet_ovf;
  bit          digit_hit;
  logic [2:0]  dot_cnt;
  logic [23:0] closed_octets;
  bit          bad_text;

  out_beat_t   quad_reports_q[$];
  logic [7:0]  text_q[$];
  bit          idle_on;
  int          stall_left;
  int          err_count;
  int          chars_sent;

  initial clk = 1'b0;

  always #4 clk = ~clk;

  function automatic void clear_parse();
    octet_val     = '0;
    octet_ovf     = 1'b0;
    digit_hit     = 1'b0;
    dot_cnt       = '0;
    closed_octets = '0;
    bad_text      = 1'b0;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    int unsigned nxt;
    if (c >= CharZero && c <= CharNine) begin
      nxt = octet_val * Radix + (c - CharZero);
      if (nxt > OctetMax) begin
        octet_ovf = 1'b1;
        nxt = OctetMax;
      end
      octet_val = nxt[7:0];
      digit_hit = 1'b1;
    end else if (c == CharDot) begin
      if (!digit_hit) bad_text = 1'b1;
      // dots past the third leave the closed octets alone
      if (dot_cnt < DotsNeeded) closed_octets = {closed_octets[15:0], octet_val};
      if (dot_cnt < DotSat) dot_cnt = dot_cnt + 3'd1;
      octet_val = '0;
      digit_hit = 1'b0;
    end else begin
      bad_text = 1'b1;
    end
  endfunction

  function automatic out_beat_t close_quad();
    out_beat_t   r;
    logic [31:0] addr;
    logic [31:0] host;
    addr_class_e cls;
    bit          ok;
    ok   = !bad_text && !octet_ovf && digit_hit && dot_cnt == DotsNeeded;
    addr = {closed_octets, octet_val};
    if (addr[31:24] <= ClassATop) begin
      cls = ClassA; host = 32'h00FF_FFFF;
    end else if (addr[31:24] <= ClassBTop) begin
      cls = ClassB; host = 32'h0000_FFFF;
    end else if (addr[31:24] <= ClassCTop) begin
      cls = ClassC; host = 32'h0000_00FF;
    end else if (addr[31:24] <= ClassDTop) begin
      cls = ClassD; host = '0;
    end else begin
      cls = ClassE; host = '0;
    end
    r.addr_valid     = ok;
    r.parsed_addr    = ok ? addr : '0;
    r.addr_class     = ok ? cls : ClassA;
    r.network_addr   = (ok && cls <= ClassC) ? (addr & ~host) : '0;
    r.broadcast_addr = (ok && cls <= ClassC) ? (addr | host) : '0;
    clear_parse();
    return r;
  endfunction

  // Entered and left at a falling edge; valid stays high unless an idle burst follows.
  task automatic send_char(logic [7:0] c, logic last);
    in_valid = 1'b1;
    in_data.char_code = c;
    in_data.last_char = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    chars_sent++;
    scan_char(c);
    if (last) quad_reports_q.push_back(close_quad());
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  function automatic void add_text(string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endfunction

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_string(string s);
    add_text(s);
    send_text();
  endtask

  function automatic void add_octet();
    int unsigned v;
    if ($urandom_range(0, 19) == 0) v = $urandom_range(256, 2999);
    else v = $urandom_range(0, 255);
    if ($urandom_range(0, 7) == 0) add_text("0");
    add_text($sformatf("%0d", v));
  endfunction

  task automatic send_random_quad(bit mangle);
    int pos;
    for (int o = 0; o < 4; o++) begin
      add_octet();
      if (o < 3) text_q.push_back(CharDot);
    end
    if (mangle) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 3))
        0: text_q.delete(pos);
        1: text_q.insert(pos, 8'($urandom_range(0, 255)));
        2: text_q.insert(pos, CharDot);
        default: text_q[pos] = 8'($urandom_range(0, 255));
      endcase
    end
    send_text();
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0, 1: text_q.push_back(8'(CharZero + $urandom_range(0, 9)));
        2: text_q.push_back(CharDot);
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    send_text();
  endtask

  // Output side: random stall bursts while idling is on.
  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (quad_reports_q.size() == 0) begin
        $error("unexpected result beat");
        err_count++;
      end else begin
        want = quad_reports_q.pop_front();
        if (out_data.addr_valid !== want.addr_valid) begin
          $error("addr_valid: expected %0d, got %0d", want.addr_valid, out_data.addr_valid);
          err_count++;
        end
        if (out_data.parsed_addr !== want.parsed_addr) begin
          $error("parsed_addr: expected %h, got %h", want.parsed_addr, out_data.parsed_addr);
          err_count++;
        end
        if (out_data.addr_class !== want.addr_class) begin
          $error("addr_class: expected %0d, got %0d", want.addr_class, out_data.addr_class);
          err_count++;
        end
        if (out_data.network_addr !== want.network_addr) begin
          $error("network_addr: expected %h, got %h", want.network_addr,
                 out_data.network_addr);
          err_count++;
        end
        if (out_data.broadcast_addr !== want.broadcast_addr) begin
          $error("broadcast_addr: expected %h, got %h", want.broadcast_addr,
                 out_data.broadcast_addr);
          err_count++;
        end
      end
    end
  end

  task automatic test_class_edges();
    send_string("0.0.0.0");
    send_string("127.255.0.1");
    send_string("128.0.0.0");
    send_string("191.255.1.2");
    send_string("192.168.1.77");
    send_string("223.1.2.3");
    send_string("224.0.0.1");
    send_string("239.255.255.255");
    send_string("240.0.0.1");
    send_string("255.255.255.255");
    send_string("010.001.0.9");
  endtask

  task automatic test_malformed_text();
    send_string("1.2.3");
    send_string("1.2.3.4.5");
    send_string("........9");
    send_string("1..3.4");
    send_string(".1.2.3");
    send_string("1.2.3.");
    send_string("256.1.1.1");
    send_string("1.2.3.2550");
    send_string("1.2.x.4");
    send_string("9");
    // control and high codes, then a lone terminating dot
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    send_string(".");
  endtask

  task automatic test_random_text();
    int n;
    int r;
    n = 0;
    while (chars_sent < 1400) begin
      // alternate busy and calm stretches
      if (n % 16 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r < 6) send_random_quad(1'b0);
      else if (r < 8) send_random_quad(1'b1);
      else send_noise();
      n++;
    end
  endtask

  task automatic test_steady_tail();
    idle_on = 1'b0;
    repeat (12) send_random_quad(1'b0);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    idle_on    = 1'b1;
    stall_left = 0;
    err_count  = 0;
    chars_sent = 0;
    clear_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_class_edges();
    test_malformed_text();
    test_random_text();
    test_steady_tail();

    in_valid = 1'b0;
    idle_on  = 1'b0;
    while (quad_reports_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

/* dotted_quad_ipv4_parse_classify.f */
+incdir+sv
sv/dqip_pkg.sv
sv/dotted_quad_ipv4_parse_classify.sv
test/testbench.sv
